// ----- src/assert_macros.svh -----
// Assertion macros for the RTL of the sorted priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/spq_pkg.sv -----
// Package with the types and constants of the sorted priority queue.
`default_nettype none

package spq_pkg;

    // Default number of cells in the queue.
    localparam int unsigned DEFAULT_CAPACITY = 16;

    // Operation codes of a request.
    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    // Status codes of a result.
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // One request transaction.
    typedef struct packed {
        op_t                op;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } request_t;

    // One result transaction.
    typedef struct packed {
        status_t            status;
        logic signed [31:0] out_value;
        logic signed [31:0] out_priority;
        logic [4:0]         occupancy;
    } result_t;

    // One stored entry of the queue.
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } entry_t;

    // Per-cycle commands broadcast to every cell.
    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/spq_cell.sv -----
// One cell of the sorted queue: holds an entry and shifts it left or right.
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occupied,
    input  wire entry_t     new_entry,
    input  wire entry_t     left_entry,
    input  wire logic       left_take,
    input  wire entry_t     right_entry,
    output entry_t          entry,
    output logic            take
);

    entry_t entry_reg;
    entry_t entry_next;

    // A cell gives way on insert unless it holds an entry that stays ahead of the new one.
    assign take  = !(occupied && (entry_reg.prio <= new_entry.prio));
    assign entry = entry_reg;

    // The first cell that gives way takes the new entry; the ones after it shift right.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en && take)
        begin
            entry_next = left_take ? left_entry : new_entry;
        end
        else if (ctrl.rem_en)
        begin
            entry_next = right_entry;
        end
    end

    // Entry storage; its contents matter only while the cell is occupied.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ----- src/sorted_priority_queue_top.sv -----
// Top level of the sorted priority queue: a row of cells plus count and result logic.
//
//   Channel   Ports                     Handshake
//   request   start, busy, request      taken on a clock edge with start high, busy low
//   result    done, result              done high for one cycle per transaction
//
// Every cell compares its priority with the incoming one in parallel, so a request
// is taken in every cycle and busy stays low. The result of a transaction is registered
// and appears on the result ports in the cycle after it is taken, where it stays until
// the next transaction is taken. Reset empties the queue at once; the cell contents need
// no clearing. The receiver cannot stall the result channel.
`default_nettype none
`include "assert_macros.svh"

module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int unsigned CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire request_t request,
    output logic          done,
    output result_t       result
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             done_next;
    result_t          result_reg;
    result_t          result_next;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    cell_ctrl_t ctrl;
    entry_t     new_entry;
    entry_t     cell_entry [CAPACITY];
    logic       cell_take  [CAPACITY];

    // Request decode.
    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign is_full   = (count_reg == CNT_MAX);
    assign is_empty  = (count_reg == '0);
    assign ctrl.ins_en = accept && (request.op == OP_INSERT) && !is_full;
    assign ctrl.rem_en = accept && (request.op == OP_REMOVE) && !is_empty;
    assign new_entry.value = request.item_value;
    assign new_entry.prio  = request.item_priority;

    // The row of cells, each linked to its neighbors; the first cell sees the new entry on its left.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t left_entry;
        logic   left_take;
        entry_t right_entry;

        if (i == 0)
        begin : g_first
            assign left_entry = new_entry;
            assign left_take  = 1'b0;
        end
        else
        begin : g_inner
            assign left_entry = cell_entry[i-1];
            assign left_take  = cell_take[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (CNT_W'(i) < count_reg),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .left_take   (left_take),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .take        (cell_take[i])
        );
    end

    // Entry count update.
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.rem_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Result of the transaction taken in this cycle.
    always_comb
    begin
        done_next                = accept;
        result_next.out_value    = '0;
        result_next.out_priority = '0;
        result_next.occupancy    = 5'(count_next);
        case (request.op)
            OP_INSERT:
            begin
                result_next.status = is_full ? ST_FULL : ST_INSERTED;
            end
            OP_REMOVE:
            begin
                result_next.status = is_empty ? ST_EMPTY : ST_REMOVED;
                if (!is_empty)
                begin
                    result_next.out_value    = cell_entry[0].value;
                    result_next.out_priority = cell_entry[0].prio;
                end
            end
            default:
            begin
                result_next.status = ST_EMPTY;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Checks on the queue logic.
    `ASSERT_NEXT(a_result_follows, accept, done, "Taken transaction gave no result.")
    `ASSERT_IMPL(a_full_keeps, done && (result.status == ST_FULL), count_reg == CNT_MAX, "Rejected insert changed the queue.")
    `ASSERT_IMPL(a_empty_keeps, done && (result.status == ST_EMPTY), (count_reg == '0) && (result.occupancy == 5'd0), "Remove on empty queue changed the queue.")
    `ASSERT_IMPL(a_head_sorted, count_reg >= CNT_W'(2), cell_entry[0].prio <= cell_entry[1].prio, "Head entries out of order.")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for the sorted priority queue: directed and random insert/remove traffic checked against a behavioral queue.
module tb_top;
    import spq_pkg::*;

    localparam int CAPACITY    = DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;

    logic     clk;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     done;
    result_t  result;

    // Behavioral copy of the queue contents, kept in service order.
    logic signed [31:0] slot_value [CAPACITY];
    logic signed [31:0] slot_prio  [CAPACITY];
    int                 entry_count = 0;

    // Results predicted for accepted transactions, oldest first.
    result_t pending_results [$];

    int err_count     = 0;
    int cycle_count   = 0;
    int idle_pct      = 0;
    int checked_count = 0;
    int insert_count  = 0;
    int remove_count  = 0;
    int full_count    = 0;
    int empty_count   = 0;
    int peak_count    = 0;

    sorted_priority_queue_top #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .done   (done),
        .result (result)
    );

    // Free-running 2 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("FAIL sorted_priority_queue_top");
            $finish;
        end
    end

    // Applies one transaction to the behavioral queue and returns its result.
    function automatic result_t queue_step(request_t req);
        result_t res;
        int      pos;
        res = '0;
        if (req.op == OP_INSERT)
        begin
            if (entry_count >= CAPACITY)
                res.status = ST_FULL;
            else
            begin
                // New entry goes behind every entry of equal or lower priority number.
                pos = 0;
                while (pos < entry_count &&
                       $signed(slot_prio[pos]) <= $signed(req.item_priority))
                    pos++;
                for (int i = entry_count; i > pos; i--)
                begin
                    slot_value[i] = slot_value[i - 1];
                    slot_prio[i]  = slot_prio[i - 1];
                end
                slot_value[pos] = req.item_value;
                slot_prio[pos]  = req.item_priority;
                entry_count++;
                res.status = ST_INSERTED;
            end
        end
        else
        begin
            if (entry_count == 0)
                res.status = ST_EMPTY;
            else
            begin
                res.out_value    = slot_value[0];
                res.out_priority = slot_prio[0];
                for (int i = 1; i < entry_count; i++)
                begin
                    slot_value[i - 1] = slot_value[i];
                    slot_prio[i - 1]  = slot_prio[i];
                end
                entry_count--;
                res.status = ST_REMOVED;
            end
        end
        res.occupancy = entry_count[4:0];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // Checks each result against the oldest prediction, then predicts the transaction taken now.
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                got = result;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with nothing pending: expected none, actual %0h",
                             $time, got);
                    err_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("out_value", want.out_value, got.out_value);
                    check_field("out_priority", want.out_priority, got.out_priority);
                    check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
                    checked_count++;
                end
            end
            else if (done !== 1'b0)
            begin
                $display("%0t: done is unknown: expected 0 or 1, actual %b", $time, done);
                err_count++;
            end
            if (start && busy === 1'b0)
            begin
                want = queue_step(request);
                pending_results.push_back(want);
                case (want.status)
                    ST_INSERTED: insert_count++;
                    ST_REMOVED:  remove_count++;
                    ST_EMPTY:    empty_count++;
                    ST_FULL:     full_count++;
                    default:     ;
                endcase
                if (entry_count > peak_count)
                    peak_count = entry_count;
            end
        end
    end

    // Holds start low for a number of cycles, with junk on the request bus.
    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start   <= 1'b0;
            request <= {1'($urandom), $urandom, $urandom};
        end
    endtask

    // Drives one transaction, waits until it is taken, and sometimes idles after it.
    task automatic send_request(input op_t op, input logic [31:0] val,
                                input logic [31:0] prio);
        request_t req;
        req.op            = op;
        req.item_value    = val;
        req.item_priority = prio;
        @(negedge clk);
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if ($urandom_range(99) < idle_pct)
            idle_cycles($urandom_range(1, 4));
    endtask

    // Stops sending until every pending result has come back.
    task automatic wait_for_drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Extremes of both fields, ties at one priority, and removes on an empty queue.
    task automatic test_directed();
        idle_pct = 0;
        send_request(OP_REMOVE, $urandom, $urandom);
        send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_INSERT, 32'd11, 32'd5);
        send_request(OP_INSERT, 32'd12, 32'd5);
        send_request(OP_INSERT, 32'd13, 32'd5);
        send_request(OP_INSERT, 32'd14, 32'h8000_0000);
        repeat (8)
            send_request(OP_REMOVE, $urandom, $urandom);
        send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Fills the queue, tries inserts that must be rejected, then empties it.
    task automatic test_full_queue();
        idle_pct = 0;
        repeat (CAPACITY)
            send_request(OP_INSERT, $urandom, $urandom_range(0, 3));
        send_request(OP_INSERT, 32'h1234_5678, 32'h8000_0000);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        repeat (CAPACITY)
            send_request(OP_REMOVE, $urandom, $urandom);
        send_request(OP_REMOVE, $urandom, $urandom);
    endtask

    // Random traffic in runs that lean toward filling, draining or holding level.
    task automatic test_random(input int n_items, input int sender_idle);
        int          run_left;
        int          ins_pct;
        int          pick;
        logic [31:0] prio;
        op_t         op;
        idle_pct = sender_idle;
        run_left = 0;
        ins_pct  = 50;
        for (int n = 0; n < n_items; n++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(8, 40);
                pick     = $urandom_range(2);
                ins_pct  = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
            end
            run_left--;
            pick = $urandom_range(9);
            if (pick < 5)
                prio = $urandom_range(0, 7) - 4;
            else if (pick < 8)
                prio = $urandom;
            else
            begin
                case ($urandom_range(3))
                    0:       prio = 32'h8000_0000;
                    1:       prio = 32'h7FFF_FFFF;
                    2:       prio = 32'hFFFF_FFFF;
                    default: prio = 32'h0000_0000;
                endcase
            end
            op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
            send_request(op, $urandom, prio);
        end
    endtask

    // Test sequence.
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full_queue();
        test_random(220, 31);
        wait_for_drain();
        test_random(220, 45);
        test_random(200, 0);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d inserts, %0d removes, %0d full rejections, %0d empty removes.",
                 insert_count, remove_count, full_count, empty_count);
        $display("Peak fill %0d of %0d; %0d results checked, %0d mismatches.",
                 peak_count, CAPACITY, checked_count, err_count);
        if (err_count == 0)
            $display("PASS sorted_priority_queue_top");
        else
            $display("FAIL sorted_priority_queue_top");
        $finish;
    end

endmodule
